// ===== hdl/bmam_pkg.sv =====
// ----------------------------------------------------------------------------
// bmam_pkg
// Shared types and constants for the banked memory address mapper.
// ----------------------------------------------------------------------------
package bmam_pkg;

	// Request types.
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_BANK  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_REMAP    = 1'b0;
	localparam logic CFG_SCRAMBLE = 1'b1;

	// Region codes.
	localparam logic [3:0] REGION_OPEN   = 4'd0;
	localparam logic [3:0] REGION_SCREEN = 4'd1;
	localparam logic [3:0] REGION_COLOUR = 4'd2;
	localparam logic [3:0] REGION_BASIC  = 4'd3;
	localparam logic [3:0] REGION_FLASH  = 4'd4;
	localparam logic [3:0] REGION_CART   = 4'd5;
	localparam logic [3:0] REGION_VIDEO  = 4'd6;
	localparam logic [3:0] REGION_CHAR   = 4'd7;
	localparam logic [3:0] REGION_MAIN   = 4'd8;

	// Special page numbers.
	localparam logic [5:0] PAGE_CART  = 6'd19;
	localparam logic [5:0] PAGE_VIDEO = 6'd20;
	localparam logic [5:0] PAGE_CHAR  = 6'd21;

	// Boundaries within a 16K quarter.
	localparam logic [13:0] OVL_SCREEN_BASE = 14'h3000;
	localparam logic [13:0] OVL_COLOUR_BASE = 14'h3400;
	localparam logic [13:0] OVL_BASIC_BASE  = 14'h3800;
	localparam logic [13:0] CHAR_SIZE       = 14'h0800;

	// Fields of one bank register, as seen by the decoder.
	typedef struct packed {
		logic       rdonly;
		logic       overlay;
		logic [5:0] page;
	} bank_info_t;

	// One translated access.
	typedef struct packed {
		logic [3:0]  region;
		logic [18:0] offset;
		logic        write_enable;
		logic [7:0]  read_xor;
		logic [7:0]  write_data;
	} result_t;

endpackage

// ===== hdl/bmam_bank_file.sv =====
// ----------------------------------------------------------------------------
// bmam_bank_file
// Four bank registers with one write port and one read port. The read port
// applies the optional swap of the lowest and highest quarters.
// ----------------------------------------------------------------------------
module bmam_bank_file (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [1:0]           wr_sel,
	input  logic [7:0]           wr_data,
	input  logic                 remap_enable,
	input  logic [1:0]           rd_quarter,
	output bmam_pkg::bank_info_t rd_info
);
	import bmam_pkg::*;

	logic [7:0] bank_q [4];
	logic       swap;
	logic [1:0] rd_sel;

	// Quarters 0 and 3 trade places when remapping is on.
	assign swap   = remap_enable & (rd_quarter[1] == rd_quarter[0]);
	assign rd_sel = rd_quarter ^ {2{swap}};

	// Bank register storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				bank_q[i] <= 8'd0;
			end
		end else if (wr_en) begin
			bank_q[wr_sel] <= wr_data;
		end
	end

	// Split the selected register into its fields.
	assign rd_info.rdonly  = bank_q[rd_sel][7];
	assign rd_info.overlay = bank_q[rd_sel][6];
	assign rd_info.page    = bank_q[rd_sel][5:0];

endmodule

// ===== hdl/bmam_decode.sv =====
// ----------------------------------------------------------------------------
// bmam_decode
// Combinational translation of one request into region, offset, write enable
// and read mask, given the bank register that covers its quarter.
// ----------------------------------------------------------------------------
module bmam_decode (
	input  logic                 [1:0]  req_type,
	input  logic                 [13:0] off,
	input  logic                 [7:0]  cpu_data,
	input  logic                 [7:0]  scramble_key,
	input  bmam_pkg::bank_info_t        info,
	output bmam_pkg::result_t           res
);
	import bmam_pkg::*;

	logic        is_mem;
	logic        is_write;
	logic [3:0]  region;
	logic [18:0] offset;
	logic        writable;

	assign is_mem   = (req_type == REQ_READ) || (req_type == REQ_WRITE);
	assign is_write = (req_type == REQ_WRITE);

	// Region decode, overlay first, then by page.
	always_comb begin
		region   = REGION_OPEN;
		offset   = 19'd0;
		writable = 1'b0;
		if (info.overlay && off >= OVL_SCREEN_BASE) begin
			writable = 1'b1;
			if (off < OVL_COLOUR_BASE) begin
				region = REGION_SCREEN;
				offset = {9'd0, off[9:0]};
			end else if (off < OVL_BASIC_BASE) begin
				region = REGION_COLOUR;
				offset = {9'd0, off[9:0]};
			end else begin
				region = REGION_BASIC;
				offset = {8'd0, off[10:0]};
			end
		end else if (info.page[5:4] == 2'b00) begin
			region = REGION_FLASH;
			offset = {1'b0, info.page[3:0], off};
		end else if (info.page == PAGE_CART) begin
			region = REGION_CART;
			offset = {5'd0, off};
		end else if (info.page == PAGE_VIDEO) begin
			region   = REGION_VIDEO;
			offset   = {5'd0, off};
			writable = !info.rdonly;
		end else if (info.page == PAGE_CHAR) begin
			if (off < CHAR_SIZE) begin
				region   = REGION_CHAR;
				offset   = {5'd0, off};
				writable = !info.rdonly;
			end
		end else if (info.page[5]) begin
			region   = REGION_MAIN;
			offset   = {info.page[4:0], off};
			writable = !info.rdonly;
		end
	end

	// Bank writes and unused request types report an all-zero result.
	always_comb begin
		res = '0;
		if (is_mem) begin
			res.region       = region;
			res.offset       = offset;
			res.write_enable = is_write & writable;
			res.read_xor     = (region == REGION_CART) ? scramble_key : 8'd0;
			res.write_data   = is_write ? cpu_data : 8'd0;
		end
	end

endmodule

// ===== hdl/banked_memory_address_mapper.sv =====
// ----------------------------------------------------------------------------
// banked_memory_address_mapper
// Maps 16-bit CPU accesses through four bank registers onto physical regions.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_stall | req_type, cpu_address, cpu_data
//  out     | output    | out_valid/out_stall | region, offset, write_enable,
//          |           |                     | read_xor, write_data
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A request is registered, decoded in the next cycle and its result is held
// in the output register; one transaction per cycle while out_stall is low.
// A bank register write takes effect as it leaves the input register, so the
// transaction right behind it already sees the new value.
// Reset clears the bank registers, the configuration and both valid flags.
// in_stall rises only when the input register is full and the output register
// holds a result that is stalled.
// ----------------------------------------------------------------------------
module banked_memory_address_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] cpu_address,
	input  logic [7:0]  cpu_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  region,
	output logic [18:0] offset,
	output logic        write_enable,
	output logic [7:0]  read_xor,
	output logic [7:0]  write_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import bmam_pkg::*;

	logic        remap_q;
	logic [7:0]  scramble_q;
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic        load_s2;
	logic        adv_s1;
	logic        accept;
	logic        bank_we;
	bank_info_t  info;
	result_t     res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remap_q    <= 1'b0;
			scramble_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REMAP:    remap_q    <= cfg_data[0];
				CFG_SCRAMBLE: scramble_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Pipeline flow control.
	assign load_s2  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && load_s2;
	assign in_stall = valid_s1 && !load_s2;
	assign accept   = in_valid && !in_stall;
	assign bank_we  = adv_s1 && (req_s1 == REQ_BANK);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			addr_s1 <= cpu_address;
			data_s1 <= cpu_data;
		end
	end

	// Bank registers and quarter lookup.
	bmam_bank_file u_bank_file (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (bank_we),
		.wr_sel       (addr_s1[1:0]),
		.wr_data      (data_s1),
		.remap_enable (remap_q),
		.rd_quarter   (addr_s1[15:14]),
		.rd_info      (info)
	);

	// Region and offset decode.
	bmam_decode u_decode (
		.req_type     (req_s1),
		.off          (addr_s1[13:0]),
		.cpu_data     (data_s1),
		.scramble_key (scramble_q),
		.info         (info),
		.res          (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign region       = res_s2.region;
	assign offset       = res_s2.offset;
	assign write_enable = res_s2.write_enable;
	assign read_xor     = res_s2.read_xor;
	assign write_data   = res_s2.write_data;

`ifndef ASSERT_OFF
	// Flash, cartridge ROM and open bus are never written.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_enable) |->
			(region != REGION_OPEN && region != REGION_FLASH && region != REGION_CART))
		else $error("write enable on a region that cannot be written");

	// The read mask is only ever applied to cartridge ROM.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && region != REGION_CART) |-> (read_xor == 8'd0))
		else $error("read mask on a region other than cartridge ROM");

	// A bank write leaves an all-zero result behind it.
	assert property (@(posedge clk) disable iff (!arst_n)
		bank_we |=> (out_valid && region == REGION_OPEN && !write_enable
			&& offset == 19'd0))
		else $error("bank write produced a nonzero result");

	// The input side only stalls while the output holds a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a stalled output");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the banked memory address mapper. Requests are
// driven through the valid/stall input channel, and each accepted transaction
// is translated by a behavioral model of the bank decode. Every translated
// access that leaves the block is compared field by field with the oldest
// prediction. The run covers directed corner cases, quarter remapping,
// random traffic under several idle and stall patterns, and a long output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmam_pkg::*;

	// Request code that the block ignores.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int PIPE_LATENCY    = 2;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 300000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = '0;
	logic [15:0] cpu_address = '0;
	logic [7:0]  cpu_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  region;
	logic [18:0] offset;
	logic        write_enable;
	logic [7:0]  read_xor;
	logic [7:0]  write_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	// Model of the mapper state and configuration.
	bank_info_t bank_model [4];
	logic       remap_model = 1'b0;
	logic [7:0] key_model = 8'h00;

	// Translations that are still on their way out of the block.
	result_t pending_translations [$];

	int mismatch_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_off_requests = 0;
	int hold_off_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;

	banked_memory_address_mapper dut (.*);

	always #1 clk = ~clk;

	initial begin
		for (int i = 0; i < 4; i++) begin
			bank_model[i] = '0;
		end
	end

	// Expected translation of one request; bank writes update the model.
	function automatic result_t translate_access(logic [1:0] kind, logic [15:0] addr,
			logic [7:0] data);
		result_t    res;
		logic [1:0] quarter;
		logic [13:0] off;
		bank_info_t bank;
		logic       writable;
		res = '0;
		writable = 1'b0;
		if (kind == REQ_BANK) begin
			bank_model[addr[1:0]] = data;
			return res;
		end
		if (kind != REQ_READ && kind != REQ_WRITE) begin
			return res;
		end
		// Remap exchanges the lowest and highest quarters; inverting swaps 0 and 3.
		quarter = addr[15:14];
		if (remap_model && (quarter == 2'd0 || quarter == 2'd3)) begin
			quarter = ~quarter;
		end
		off = addr[13:0];
		bank = bank_model[quarter];
		if (bank.overlay && off >= OVL_SCREEN_BASE) begin
			// The overlay is writable even in a read-only bank.
			writable = 1'b1;
			if (off < OVL_COLOUR_BASE) begin
				res.region = REGION_SCREEN;
				res.offset = 19'(off[9:0]);
			end else if (off < OVL_BASIC_BASE) begin
				res.region = REGION_COLOUR;
				res.offset = 19'(off[9:0]);
			end else begin
				res.region = REGION_BASIC;
				res.offset = 19'(off[10:0]);
			end
		end else if (bank.page < 6'd16) begin
			res.region = REGION_FLASH;
			res.offset = 19'({bank.page[3:0], off});
		end else if (bank.page == PAGE_CART) begin
			res.region = REGION_CART;
			res.offset = 19'(off);
		end else if (bank.page == PAGE_VIDEO) begin
			res.region = REGION_VIDEO;
			res.offset = 19'(off);
			writable = !bank.rdonly;
		end else if (bank.page == PAGE_CHAR) begin
			if (off < CHAR_SIZE) begin
				res.region = REGION_CHAR;
				res.offset = 19'(off);
				writable = !bank.rdonly;
			end
		end else if (bank.page[5]) begin
			res.region = REGION_MAIN;
			res.offset = {bank.page[4:0], off};
			writable = !bank.rdonly;
		end
		res.write_enable = (kind == REQ_WRITE) && writable;
		res.read_xor = (res.region == REGION_CART) ? key_model : 8'h00;
		res.write_data = (kind == REQ_WRITE) ? data : 8'h00;
		return res;
	endfunction

	function automatic void compare_field(string name, logic [18:0] want, logic [18:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Compare every transaction leaving the block with the oldest prediction.
	always @(posedge clk) begin : check_translations
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_translations.size() == 0) begin
				$error("region: expected no transaction, got %0h", region);
				mismatch_count++;
			end else begin
				want = pending_translations.pop_front();
				compare_field("region", 19'(want.region), 19'(region));
				compare_field("offset", want.offset, offset);
				compare_field("write_enable", 19'(want.write_enable), 19'(write_enable));
				compare_field("read_xor", 19'(want.read_xor), 19'(read_xor));
				compare_field("write_data", 19'(want.write_data), 19'(write_data));
			end
		end
	end

	// Output stall: random, or held high for a long stretch on request.
	always @(negedge clk) begin
		if (hold_off_requests != hold_off_seen) begin
			hold_off_seen = hold_off_requests;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Offer one request from a falling edge until it is accepted.
	task automatic send_request(logic [1:0] kind, logic [15:0] addr, logic [7:0] data);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		cpu_address <= addr;
		cpu_data <= data;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		pending_translations.push_back(translate_access(kind, addr, data));
		@(negedge clk);
	endtask

	// Random request, biased toward the overlay window, the char window and
	// the special pages.
	task automatic send_random_request();
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [5:0]  page;
		int          pick;
		pick = $urandom_range(99);
		addr = 16'($urandom);
		data = 8'($urandom);
		if (pick < 14) begin
			kind = REQ_BANK;
			case ($urandom_range(5))
				0: page = 6'($urandom_range(15));
				1: page = PAGE_CART;
				2: page = PAGE_VIDEO;
				3: page = PAGE_CHAR;
				4: page = 6'($urandom_range(63));
				default: page = 6'(32 + $urandom_range(31));
			endcase
			data[5:0] = page;
		end else if (pick < 18) begin
			kind = REQ_UNUSED;
		end else begin
			kind = (pick < 59) ? REQ_READ : REQ_WRITE;
			case ($urandom_range(3))
				0: addr[13:12] = 2'b11;
				1: addr[13:11] = 3'b000;
				default: ;
			endcase
		end
		send_request(kind, addr, data);
	endtask

	// Drop valid and wait until every translation has come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_translations.size() != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_REMAP: remap_model = value[0];
			CFG_SCRAMBLE: key_model = value;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Field extremes, every region, overlay priority and read-only handling.
	task automatic test_directed();
		cfg_write(CFG_SCRAMBLE, 8'hFF);
		send_request(REQ_READ, 16'h0000, 8'h00);
		send_request(REQ_WRITE, 16'hFFFF, 8'hFF);
		send_request(REQ_BANK, 16'h0001, 8'h0F);
		send_request(REQ_READ, 16'h7FFF, 8'h00);
		send_request(REQ_BANK, 16'hFFFE, 8'h13);
		send_request(REQ_READ, 16'h8000, 8'h00);
		send_request(REQ_WRITE, 16'hBFFF, 8'h5A);
		// Overlay over video in the top quarter.
		send_request(REQ_BANK, 16'h0003, 8'h54);
		send_request(REQ_WRITE, 16'hF000, 8'h01);
		send_request(REQ_READ, 16'hF7FF, 8'h00);
		send_request(REQ_WRITE, 16'hFFFF, 8'h80);
		send_request(REQ_WRITE, 16'hEFFF, 8'h7E);
		// Read-only char bank with overlay: char write blocked, overlay not.
		send_request(REQ_BANK, 16'h0000, 8'hD5);
		send_request(REQ_WRITE, 16'h07FF, 8'h33);
		send_request(REQ_READ, 16'h0800, 8'h00);
		send_request(REQ_WRITE, 16'h3000, 8'hA5);
		// Main RAM at the last page, read-only, then writable at the first.
		send_request(REQ_BANK, 16'h0001, 8'hBF);
		send_request(REQ_WRITE, 16'h7FFF, 8'h11);
		send_request(REQ_BANK, 16'h0001, 8'h20);
		send_request(REQ_WRITE, 16'h4000, 8'hC3);
		// Unmapped page and the ignored request code.
		send_request(REQ_BANK, 16'h0002, 8'h11);
		send_request(REQ_WRITE, 16'h8000, 8'h22);
		send_request(REQ_UNUSED, 16'hFFFF, 8'hFF);
		// Overlay takes priority over cart ROM.
		send_request(REQ_BANK, 16'h0002, 8'h53);
		send_request(REQ_READ, 16'hB000, 8'h00);
		send_request(REQ_READ, 16'hAFFF, 8'h00);
	endtask

	// Swap of the lowest and highest quarters, with the scramble key cleared.
	task automatic test_remap();
		wait_idle();
		cfg_write(CFG_REMAP, 8'h01);
		cfg_write(CFG_SCRAMBLE, 8'h00);
		send_request(REQ_READ, 16'h0000, 8'h00);
		send_request(REQ_WRITE, 16'hC000, 8'h44);
		send_request(REQ_WRITE, 16'h4000, 8'h55);
		send_request(REQ_READ, 16'h8000, 8'h00);
	endtask

	task automatic run_random_phase(int count, logic remap, logic [7:0] key, int src_pct,
			int sink_pct);
		wait_idle();
		cfg_write(CFG_REMAP, {7'b0, remap});
		cfg_write(CFG_SCRAMBLE, key);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		repeat (count) send_random_request();
	endtask

	// Random traffic under each idling pattern and several register settings.
	task automatic test_random_traffic();
		run_random_phase(400, 1'b0, 8'h00, 0, 0);
		run_random_phase(400, 1'b1, 8'hFF, 66, 0);
		run_random_phase(400, 1'b0, 8'($urandom), 0, 66);
		run_random_phase(400, 1'b1, 8'($urandom), 9, 9);
	endtask

	// Long output hold-off while requests keep coming, so the input stalls.
	task automatic test_backpressure();
		wait_idle();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_off_requests++;
		repeat (60) send_random_request();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_remap();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/bmam_pkg.sv
hdl/bmam_bank_file.sv
hdl/bmam_decode.sv
hdl/banked_memory_address_mapper.sv
test/tb_top.sv
